/* rtl/core/utf8d_pkg.sv */
// Shared types, codes and lead-byte classification for the UTF-8 decoder.
package utf8d_pkg;

   localparam int unsigned CP_WIDTH      = 21;
   localparam int unsigned KIND_WIDTH    = 2;
   localparam int unsigned SEQ_MAX       = 4;
   localparam int unsigned SEQ_IDX_WIDTH = $clog2(SEQ_MAX);
   localparam int unsigned REQ_DEPTH     = 2;
   localparam int unsigned REQ_PTR_WIDTH = $clog2(REQ_DEPTH);
   localparam int unsigned RSP_DEPTH     = 4;
   localparam int unsigned RSP_PTR_WIDTH = $clog2(RSP_DEPTH);

   localparam logic [KIND_WIDTH-1:0] KIND_CP  = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_ERR = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_END = 2'd2;

   // Request after classification in the front queue.
   typedef struct packed {
      logic [7:0] data;
      logic       is_zero;
      logic [2:0] len;
   } req_item_type;

   // One result headed for the response queue.
   typedef struct packed {
      logic [CP_WIDTH-1:0]   code_point;
      logic [KIND_WIDTH-1:0] kind;
      logic                  last_of_run;
   } rsp_item_type;

   // Sequence length of a lead byte, zero when it cannot start a sequence.
   function automatic logic [2:0] lead_len(input logic [7:0] b);
      logic [2:0] len;
      priority if (b[7] == 1'b0) begin
         len = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         len = 3'd4;
      end else begin
         len = 3'd0;
      end
      return len;
   endfunction

endpackage

/* rtl/core/utf8d_front.sv */
// Front end: accepts request bytes, classifies them and queues them for the decoder.
module utf8d_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [7:0]            req_data_byte,
   input  logic                  push,
   output logic                  full,
   output logic                  item_valid,
   output utf8d_pkg::req_item_type item,
   input  logic                  item_take
);

   utf8d_pkg::req_item_type             queue_ff [utf8d_pkg::REQ_DEPTH];
   logic [utf8d_pkg::REQ_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [utf8d_pkg::REQ_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [utf8d_pkg::REQ_PTR_WIDTH:0]   count_ff, count_in;
   logic                                do_push;
   logic                                do_take;
   utf8d_pkg::req_item_type             classified;

   assign full       = (count_ff == (utf8d_pkg::REQ_PTR_WIDTH+1)'(utf8d_pkg::REQ_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = queue_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_take    = item_take && item_valid;

   always_comb begin
      classified.data    = req_data_byte;
      classified.is_zero = (req_data_byte == 8'd0);
      classified.len     = utf8d_pkg::lead_len(req_data_byte);
   end

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_take ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_take) begin
         count_in = count_ff + (utf8d_pkg::REQ_PTR_WIDTH+1)'(1);
      end else if (do_take && !do_push) begin
         count_in = count_ff - (utf8d_pkg::REQ_PTR_WIDTH+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

/* rtl/core/utf8d_back.sv */
// Back end: sequence buffer and decode step, one result per cycle while rsp_full is low.
module utf8d_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     item_valid,
   input  utf8d_pkg::req_item_type  item,
   output logic                     item_take,
   output logic                     rsp_push,
   output utf8d_pkg::rsp_item_type  rsp_item,
   input  logic                     rsp_full
);

   logic [7:0] buf_ff [utf8d_pkg::SEQ_MAX];
   logic [7:0] buf_in [utf8d_pkg::SEQ_MAX];
   logic [2:0] held_ff, held_in;
   logic       busy_ff, busy_in;

   logic [7:0] wbuf [utf8d_pkg::SEQ_MAX];
   logic [2:0] wheld;
   logic [2:0] len;
   logic       cont_ok;
   logic       complete;
   logic       emit;
   logic       good;
   logic [2:0] drop;
   logic [7:0] nbuf [utf8d_pkg::SEQ_MAX];
   logic [2:0] nheld;
   logic [2:0] nlen;
   logic       more;
   logic       go_new;
   logic       end_req;
   logic       active;
   logic       advance;
   logic [utf8d_pkg::CP_WIDTH-1:0] cp;

   assign go_new  = !busy_ff && item_valid;
   assign end_req = go_new && item.is_zero;
   assign active  = busy_ff || (go_new && !item.is_zero);

   // Working view: the held bytes, with the new byte appended when starting.
   always_comb begin
      for (int i = 0; i < utf8d_pkg::SEQ_MAX; i++) begin
         wbuf[i] = (!busy_ff && (utf8d_pkg::SEQ_IDX_WIDTH'(i) ==
                    held_ff[utf8d_pkg::SEQ_IDX_WIDTH-1:0])) ? item.data : buf_ff[i];
      end
      wheld = busy_ff ? held_ff : held_ff + 3'd1;
   end

   always_comb begin
      len = (!busy_ff && held_ff == 3'd0) ? item.len : utf8d_pkg::lead_len(wbuf[0]);
      cont_ok = 1'b1;
      for (int i = 1; i < utf8d_pkg::SEQ_MAX; i++) begin
         if ((3'(i) < len) && (wbuf[i][7:6] != 2'b10)) begin
            cont_ok = 1'b0;
         end
      end
      complete = (len != 3'd0) && (wheld >= len);
      emit     = (len == 3'd0) || complete;
      good     = complete && cont_ok;
      drop     = good ? len : 3'd1;
   end

   always_comb begin
      unique case (len)
         3'd2:    cp = {10'd0, wbuf[0][4:0], wbuf[1][5:0]};
         3'd3:    cp = {5'd0, wbuf[0][3:0], wbuf[1][5:0], wbuf[2][5:0]};
         3'd4:    cp = {wbuf[0][2:0], wbuf[1][5:0], wbuf[2][5:0], wbuf[3][5:0]};
         default: cp = {13'd0, wbuf[0]};
      endcase
   end

   // Shift out the consumed bytes and look ahead at the next lead.
   always_comb begin
      logic [3:0] src;
      for (int i = 0; i < utf8d_pkg::SEQ_MAX; i++) begin
         src = 4'(i) + {1'b0, drop};
         if (!emit) begin
            nbuf[i] = wbuf[i];
         end else if (src < 4'(utf8d_pkg::SEQ_MAX)) begin
            nbuf[i] = wbuf[src[utf8d_pkg::SEQ_IDX_WIDTH-1:0]];
         end else begin
            nbuf[i] = wbuf[i];
         end
      end
      nheld = emit ? wheld - drop : wheld;
      nlen  = utf8d_pkg::lead_len(nbuf[0]);
      more  = emit && (nheld != 3'd0) && !((nlen != 3'd0) && (nheld < nlen));
   end

   always_comb begin
      advance   = 1'b0;
      rsp_push  = 1'b0;
      item_take = 1'b0;
      rsp_item.code_point  = '0;
      rsp_item.kind        = utf8d_pkg::KIND_CP;
      rsp_item.last_of_run = 1'b0;
      busy_in   = busy_ff;
      held_in   = held_ff;
      for (int i = 0; i < utf8d_pkg::SEQ_MAX; i++) begin
         buf_in[i] = buf_ff[i];
      end
      priority if (end_req) begin
         // End of string: drop any partial sequence.
         rsp_item.kind        = utf8d_pkg::KIND_END;
         rsp_item.last_of_run = 1'b1;
         if (!rsp_full) begin
            rsp_push  = 1'b1;
            item_take = 1'b1;
            held_in   = 3'd0;
         end
      end else if (active) begin
         rsp_item.code_point  = good ? cp : '0;
         rsp_item.kind        = good ? utf8d_pkg::KIND_CP : utf8d_pkg::KIND_ERR;
         rsp_item.last_of_run = !more;
         advance = !emit || !rsp_full;
         if (advance) begin
            rsp_push  = emit;
            item_take = go_new;
            busy_in   = more;
            held_in   = nheld;
            for (int i = 0; i < utf8d_pkg::SEQ_MAX; i++) begin
               buf_in[i] = nbuf[i];
            end
         end
      end else begin
         // idle, hold
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= 3'd0;
         busy_ff <= 1'b0;
      end else begin
         held_ff <= held_in;
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < utf8d_pkg::SEQ_MAX; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

endmodule

/* rtl/core/utf8d_rsp_fifo.sv */
// Response queue between the decode step and the result ports.
module utf8d_rsp_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  utf8d_pkg::rsp_item_type wr_item,
   output logic                    wr_full,
   output logic                    empty,
   output utf8d_pkg::rsp_item_type rd_item,
   input  logic                    pop
);

   utf8d_pkg::rsp_item_type             queue_ff [utf8d_pkg::RSP_DEPTH];
   logic [utf8d_pkg::RSP_PTR_WIDTH-1:0] wr_ptr_ff, wr_ptr_in;
   logic [utf8d_pkg::RSP_PTR_WIDTH-1:0] rd_ptr_ff, rd_ptr_in;
   logic [utf8d_pkg::RSP_PTR_WIDTH:0]   count_ff, count_in;
   logic                                do_push;
   logic                                do_pop;

   assign wr_full = (count_ff == (utf8d_pkg::RSP_PTR_WIDTH+1)'(utf8d_pkg::RSP_DEPTH));
   assign empty   = (count_ff == '0);
   assign rd_item = queue_ff[rd_ptr_ff];
   assign do_push = wr_en && !wr_full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + utf8d_pkg::RSP_PTR_WIDTH'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + utf8d_pkg::RSP_PTR_WIDTH'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (utf8d_pkg::RSP_PTR_WIDTH+1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (utf8d_pkg::RSP_PTR_WIDTH+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         queue_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

/* rtl/core/utf8_byte_stream_decoder_core.sv */
// UTF-8 byte stream decoder: top level joining front queue, decoder and response queue.
//
// Request side: drive req_data_byte and raise push; a byte is taken at a clock
// edge where push is high and full is low. A zero byte ends the string.
// Response side: while empty is low the oldest result sits on rsp_code_point,
// rsp_kind and rsp_last_of_run; raise pop to take it. rsp_last_of_run marks the
// final result caused by one request; a request that only starts or extends a
// partial sequence gives no result at all.
// Path: the front queue registers a request byte; the decode step then writes its
// first result into the response queue, which registers it onto the response
// ports, from where it can be popped.
// Throughput: one byte per cycle while each byte gives at most one result and the
// response queue has room. The decode step writes one result per cycle, so a byte
// giving more results (a bad continuation forcing the held bytes to be rerun as
// leads) holds the decoder until the last is written; up to four come from one byte.
// Stall: when the receiver stops popping, the four-entry response queue fills,
// then the decoder holds, then the two-entry front queue fills and full rises.
// Reset (synchronous, active high) empties both queues and drops any partial
// sequence.
module utf8_byte_stream_decoder_core (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        push,
   output logic        full,
   output logic [20:0] rsp_code_point,
   output logic [1:0]  rsp_kind,
   output logic        rsp_last_of_run,
   output logic        empty,
   input  logic        pop
);

   logic                    item_valid;
   utf8d_pkg::req_item_type item;
   logic                    item_take;
   logic                    rsp_push;
   utf8d_pkg::rsp_item_type rsp_wr_item;
   logic                    rsp_full;
   utf8d_pkg::rsp_item_type rsp_rd_item;

   utf8d_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .push          (push),
      .full          (full),
      .item_valid    (item_valid),
      .item          (item),
      .item_take     (item_take)
   );

   utf8d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .item_take  (item_take),
      .rsp_push   (rsp_push),
      .rsp_item   (rsp_wr_item),
      .rsp_full   (rsp_full)
   );

   utf8d_rsp_fifo u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rsp_push),
      .wr_item (rsp_wr_item),
      .wr_full (rsp_full),
      .empty   (empty),
      .rd_item (rsp_rd_item),
      .pop     (pop)
   );

   assign rsp_code_point  = rsp_rd_item.code_point;
   assign rsp_kind        = rsp_rd_item.kind;
   assign rsp_last_of_run = rsp_rd_item.last_of_run;

endmodule
